[design/encoder_delta_accumulator_assert.svh]
// Assertion macros for the encoder delta accumulator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ENCODER_DELTA_ACCUMULATOR_ASSERT_SVH
`define ENCODER_DELTA_ACCUMULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder delta accumulator check failed");

// Consequent must hold in the cycle after the antecedent.
`define EDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder delta accumulator check failed");

`endif

[design/eda_pkg.sv]
// Package for the encoder delta accumulator: sequencer states, command codes,
// register indexes and fixed field widths. No dependencies.
`default_nettype none

package eda_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ELAPSED_W   = 32;
    localparam int CLICKS_W    = 16;
    localparam int SPEED_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXP_MODE  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] MAX_COUNT_RESET = 16'hFFFF;
    localparam logic [SPEED_W-1:0]    SPEED_MAX       = 16'hFFFF;

    // Four counter steps make one detent.
    localparam int CLICK_SHIFT = 2;

    // Speed division: one range check step and one step per quotient bit.
    localparam int DIV_STEPS = SPEED_W + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Cubed output: any detent count of magnitude 32 or more saturates,
    // so the cube only ever sees six-bit signed operands.
    localparam int CUBE_W     = 6;
    localparam int CUBE_LIMIT = 32;
    localparam int CLICK_HI   = 32767;
    localparam int CLICK_LO   = -32768;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_STOP   = 2'd1,
        FUNC_SAMPLE = 2'd2,
        FUNC_READ   = 2'd3
    } eda_func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_DIST,
        ST_WRAP,
        ST_ACC,
        ST_DIV,
        ST_QUOT,
        ST_SCALE,
        ST_CUBE,
        ST_FINISH
    } eda_state_t;

endpackage

`default_nettype wire

[design/encoder_delta_accumulator.sv]
// Top level of the encoder delta accumulator: command sequencer, shared
// shift-and-subtract divider and cube multiplier. Depends on eda_pkg.
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   func, counter_sample, elapsed_ms
// out       output     out_valid / out_ready clicks, speed, running
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A read passes quotient, scale and, with the cube taken, cube; a running sample
// passes clip, distance, wrap and accumulate, then the speed division runs
// through one shared subtractor: a range check, then one quotient bit per cycle.
// Reset is asynchronous and active low; no clearing pass is needed.
// A finished result waits in the output register, so a stalled out channel
// holds at most one result there while the next item is already accepted.

module encoder_delta_accumulator
    import eda_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int TOTAL_WIDTH = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Command channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [SAMPLE_W-1:0]         counter_sample,
    input  wire logic [ELAPSED_W-1:0]        elapsed_ms,
    // Result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [CLICKS_W-1:0]       clicks,
    output logic [SPEED_W-1:0]               speed,
    output logic                             running,
    // Configuration channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int TW = TOTAL_WIDTH;
    // Bits of the sixteen-bit sample and limit that survive the count mask.
    localparam int MW = (CW < SAMPLE_W) ? CW : SAMPLE_W;
    // Width of the dividend (distance times 1000) and of the shifted divisor.
    localparam int PW = CW + 10;
    localparam int DW = ELAPSED_W + SPEED_W;
    localparam int RW = (PW > DW) ? PW : DW;
    // Accumulator sum width: room for the signed distance and one carry.
    localparam int SW = ((TW > CW + 1) ? TW : CW + 1) + 1;

    localparam logic signed [TW-1:0] TOT_MAX   = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] TOT_MIN   = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] CLICK_MAX = TW'(CLICK_HI);
    localparam logic signed [TW-1:0] CLICK_MIN = TW'(CLICK_LO);
    localparam logic signed [TW-1:0] CUBE_HI   = TW'(CUBE_LIMIT);
    localparam logic signed [TW-1:0] CUBE_LO   = TW'(-CUBE_LIMIT);
    localparam logic [STEP_W-1:0]    DIV_LAST  = STEP_W'(DIV_STEPS - 1);

    // Sequencer and kept state.
    eda_state_t state_reg, state_next;
    logic                   active_reg;
    logic [CW-1:0]          last_count_reg;
    logic signed [TW-1:0]   edge_total_reg;
    logic [SPEED_W-1:0]     speed_value_reg;
    logic [CFG_DATA_W-1:0]  max_count_reg;
    logic                   exp_mode_reg;
    logic                   out_valid_reg;

    // Working registers of the current item.
    logic [CW-1:0]              cur_reg;
    logic [CW-1:0]              prev_reg;
    logic [ELAPSED_W-1:0]       ms_reg;
    logic [CW-1:0]              direct_reg;
    logic                       up_reg;
    logic [CW-1:0]              dist_reg;
    logic                       fwd_reg;
    logic [RW-1:0]              rem_reg;
    logic [RW-1:0]              div_reg;
    logic [SPEED_W-1:0]         quot_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [TW-1:0]       q_reg;
    logic signed [2*CUBE_W-1:0] sq_reg;
    logic signed [CLICKS_W-1:0] click_res_reg;
    logic signed [CLICKS_W-1:0] clicks_reg;
    logic [SPEED_W-1:0]         speed_reg;
    logic                       running_reg;

    logic out_load;

    // Limit and sample after the count mask.
    logic [CW-1:0] top_val;
    logic [CW-1:0] sample_val;

    assign top_val    = CW'(max_count_reg[MW-1:0]);
    assign sample_val = CW'(counter_sample[MW-1:0]);

    // Shortest way round the counter: direct or wrapped distance.
    logic [CW:0] modulus_val;
    logic [CW:0] wrapped_val;
    logic        take_direct;

    assign modulus_val = {1'b0, top_val} + (CW+1)'(1);
    assign wrapped_val = modulus_val - {1'b0, direct_reg};
    assign take_direct = ({1'b0, direct_reg} <= wrapped_val);

    // Saturating accumulation of the signed distance.
    logic signed [SW-1:0] dist_ext;
    logic signed [SW-1:0] delta_val;
    logic signed [SW-1:0] total_ext;
    logic signed [SW-1:0] sum_val;
    logic signed [SW-1:0] tot_max_ext;
    logic signed [SW-1:0] tot_min_ext;
    logic signed [TW-1:0] sum_sat;

    assign dist_ext    = {{(SW-CW){1'b0}}, dist_reg};
    assign delta_val   = fwd_reg ? dist_ext : (~dist_ext + SW'(1));
    assign total_ext   = {{(SW-TW){edge_total_reg[TW-1]}}, edge_total_reg};
    assign sum_val     = total_ext + delta_val;
    assign tot_max_ext = {{(SW-TW){1'b0}}, TOT_MAX};
    assign tot_min_ext = {{(SW-TW){1'b1}}, TOT_MIN};

    always_comb
    begin
        if (sum_val > tot_max_ext)
        begin
            sum_sat = TOT_MAX;
        end
        else if (sum_val < tot_min_ext)
        begin
            sum_sat = TOT_MIN;
        end
        else
        begin
            sum_sat = sum_val[TW-1:0];
        end
    end

    // Dividend distance * 1000 as 1024 - 16 - 8 times the distance, and the
    // divisor lined up for the range check that decides saturation.
    logic [RW-1:0] dist_wide;
    logic [RW-1:0] rate_prod;
    logic [RW-1:0] div_start;

    assign dist_wide = RW'(dist_reg);
    assign rate_prod = (dist_wide << 10) - (dist_wide << 4) - (dist_wide << 3);
    assign div_start = RW'({ms_reg, {SPEED_W{1'b0}}});

    // The shared subtractor of the divider.
    logic [RW:0] sub_val;
    logic        div_ge;

    assign sub_val = {1'b0, rem_reg} - {1'b0, div_reg};
    assign div_ge  = !sub_val[RW];

    // Read: quotient by four towards zero, and the signed remainder kept.
    logic signed [TW-1:0] edge_biased;
    logic signed [TW-1:0] q_val;
    logic signed [TW-1:0] rem_val;

    assign edge_biased = edge_total_reg
                       + {{(TW-2){1'b0}}, {2{edge_total_reg[TW-1]}}};
    assign q_val       = edge_biased >>> CLICK_SHIFT;
    assign rem_val     = edge_total_reg - (q_val <<< CLICK_SHIFT);

    // Click scaling: linear saturation or a two-step cube.
    logic signed [CUBE_W-1:0]   q_small;
    logic signed [2*CUBE_W-1:0] sq_val;
    logic signed [3*CUBE_W-1:0] cube_val;
    logic                       cube_sat;
    logic signed [CLICKS_W-1:0] linear_val;
    logic signed [CLICKS_W-1:0] cube_sat_val;

    assign q_small  = q_reg[CUBE_W-1:0];
    assign sq_val   = q_small * q_small;
    assign cube_val = sq_reg * q_small;
    assign cube_sat = (q_reg >= CUBE_HI) || (q_reg <= CUBE_LO);

    always_comb
    begin
        if (q_reg > CLICK_MAX)
        begin
            linear_val = CLICK_MAX[CLICKS_W-1:0];
        end
        else if (q_reg < CLICK_MIN)
        begin
            linear_val = CLICK_MIN[CLICKS_W-1:0];
        end
        else
        begin
            linear_val = q_reg[CLICKS_W-1:0];
        end

        if (q_reg[TW-1])
        begin
            cube_sat_val = CLICK_MIN[CLICKS_W-1:0];
        end
        else
        begin
            cube_sat_val = CLICK_MAX[CLICKS_W-1:0];
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (eda_func_t'(func))
                        FUNC_START:  state_next = ST_FINISH;
                        FUNC_STOP:   state_next = ST_FINISH;
                        FUNC_SAMPLE: state_next = active_reg ? ST_CLIP : ST_FINISH;
                        default:     state_next = ST_QUOT;
                    endcase
                end
            end
            ST_CLIP:  state_next = ST_DIST;
            ST_DIST:  state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_ACC;
            ST_ACC:   state_next = ST_DIV;
            ST_DIV:
            begin
                // The first step is the range check; a hit ends the division.
                if ((step_reg == '0 && div_ge) || step_reg == DIV_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_QUOT:  state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (exp_mode_reg && !cube_sat)
                begin
                    state_next = ST_CUBE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CUBE:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                // The previous result must have left the output register.
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Kept state, configuration registers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            last_count_reg  <= '0;
            edge_total_reg  <= '0;
            speed_value_reg <= '0;
            max_count_reg   <= MAX_COUNT_RESET;
            exp_mode_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (eda_func_t'(func))
                            FUNC_START:
                            begin
                                // A start while already running changes nothing.
                                if (!active_reg)
                                begin
                                    active_reg      <= 1'b1;
                                    last_count_reg  <= '0;
                                    edge_total_reg  <= '0;
                                    speed_value_reg <= '0;
                                end
                            end
                            FUNC_STOP: active_reg <= 1'b0;
                            default:   ;
                        endcase
                    end
                end
                ST_ACC:
                begin
                    edge_total_reg <= sum_sat;
                    last_count_reg <= cur_reg;
                end
                ST_DIV:
                begin
                    if (step_reg == '0 && div_ge)
                    begin
                        speed_value_reg <= SPEED_MAX;
                    end
                    else if (step_reg == DIV_LAST)
                    begin
                        speed_value_reg <= {quot_reg[SPEED_W-2:0], div_ge};
                    end
                end
                ST_QUOT: edge_total_reg <= rem_val;
                default: ;
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_COUNT: max_count_reg <= cfg_data;
                    CFG_EXP_MODE:  exp_mode_reg  <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // Working registers of the item in progress; no reset needed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_reg       <= sample_val;
                    ms_reg        <= elapsed_ms;
                    click_res_reg <= '0;
                end
            end
            ST_CLIP:
            begin
                cur_reg  <= (cur_reg > top_val) ? top_val : cur_reg;
                prev_reg <= (last_count_reg > top_val) ? top_val : last_count_reg;
            end
            ST_DIST:
            begin
                up_reg     <= (cur_reg >= prev_reg);
                direct_reg <= (cur_reg >= prev_reg) ? cur_reg - prev_reg
                                                    : prev_reg - cur_reg;
            end
            ST_WRAP:
            begin
                // On a tie the direct distance wins.
                if (take_direct)
                begin
                    dist_reg <= direct_reg;
                    fwd_reg  <= up_reg;
                end
                else
                begin
                    dist_reg <= wrapped_val[CW-1:0];
                    fwd_reg  <= !up_reg;
                end
            end
            ST_ACC:
            begin
                rem_reg  <= rate_prod;
                div_reg  <= div_start;
                step_reg <= '0;
                quot_reg <= '0;
            end
            ST_DIV:
            begin
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg + STEP_W'(1);
                quot_reg <= {quot_reg[SPEED_W-2:0], div_ge};
                if (div_ge)
                begin
                    rem_reg <= sub_val[RW-1:0];
                end
            end
            ST_QUOT: q_reg <= q_val;
            ST_SCALE:
            begin
                sq_reg <= sq_val;
                if (!exp_mode_reg)
                begin
                    click_res_reg <= linear_val;
                end
                else
                begin
                    click_res_reg <= cube_sat_val;
                end
            end
            ST_CUBE: click_res_reg <= cube_val[CLICKS_W-1:0];
            ST_FINISH:
            begin
                if (out_load)
                begin
                    clicks_reg  <= click_res_reg;
                    speed_reg   <= speed_value_reg;
                    running_reg <= active_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign clicks    = clicks_reg;
    assign speed     = speed_reg;
    assign running   = running_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[design/eda_checker.sv]
// Port-level checker for the encoder delta accumulator, bound to the top
// level. Depends on eda_pkg and encoder_delta_accumulator_assert.svh.
`default_nettype none
`include "encoder_delta_accumulator_assert.svh"

module eda_checker
    import eda_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [CLICKS_W-1:0]   clicks,
    input wire logic [SPEED_W-1:0]    speed,
    input wire logic                  running
);

    // Items accepted whose result has not yet been transferred.
    logic [1:0] pend_reg, pend_next;

    assign pend_next = pend_reg + {1'b0, in_valid && in_ready}
                     - {1'b0, out_valid && out_ready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `EDA_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
    `EDA_ASSERT_SAME(a_result_has_item, out_valid, pend_reg != 2'd0)
    `EDA_ASSERT_SAME(a_ready_one_pending, in_ready, pend_reg == 2'd0 || pend_reg == 2'd1)
    `EDA_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(clicks) && $stable(speed) && $stable(running))

endmodule

bind encoder_delta_accumulator eda_checker u_eda_checker (.*);

`default_nettype wire

[verif/encoder_delta_accumulator_tb.sv]
// Self-checking testbench for the encoder delta accumulator: directed probes,
// a short large-total sweep and randomised command phases.
// Depends on eda_pkg and the encoder_delta_accumulator RTL only.
`timescale 1ns / 100ps

module encoder_delta_accumulator_tb
    import eda_pkg::*;
();

    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;

    // Padding after the last result, comfortably more than the longest sample
    // can still keep the block busy for.
    localparam int LATENCY_PAD = 30;

    // Indexes past the end of the register map; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam longint EDGE_HI = (longint'(1) <<< (TOTAL_W - 1)) - 1;
    localparam longint EDGE_LO = -EDGE_HI - 1;

    localparam int N_PHASES  = 7;
    localparam int PHASE_LEN = 110;
    localparam int LAST_LEN  = 60;

    // The sweep steps the counter by just under half a turn, so every sample
    // adds +32767 to the accumulated total and a few of them build a total whose detent count
    // no longer fits in the clicks field.
    localparam int SWEEP_SAMPLES = 8;
    localparam logic [15:0] SWEEP_STEP = 16'd32767;

    typedef struct packed {
        logic signed [CLICKS_W-1:0] clicks;
        logic [SPEED_W-1:0]         speed;
        logic                       running;
    } eda_result_t;

    // One directed probe; want is only used when typed is set, otherwise the
    // expectation comes from the behavioural predictor below.
    typedef struct {
        eda_func_t             op;
        logic [SAMPLE_W-1:0]   raw;
        logic [ELAPSED_W-1:0]  ms;
        bit                    typed;
        eda_result_t           want;
    } probe_row_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    func;
    logic [SAMPLE_W-1:0]           counter_sample;
    logic [ELAPSED_W-1:0]          elapsed_ms;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [CLICKS_W-1:0]    clicks;
    logic [SPEED_W-1:0]            speed;
    logic                          running;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    // Predictor copy of the register map and of the kept state.
    logic [15:0]   top_count  = MAX_COUNT_RESET;
    bit            cube_mode  = 1'b0;
    bit            enc_active = 1'b0;
    logic [15:0]   enc_last   = '0;
    longint        edge_sum   = 0;
    logic [15:0]   speed_reg  = '0;

    // Results still owed by the block, oldest first.
    eda_result_t   pending_results [$];
    int            error_count = 0;

    // Traffic shaping for the two channel drivers.
    bit            source_gaps = 1'b0;
    bit            sink_stalls = 1'b0;
    int            hold_off    = 0;

    // Directed probes, run from reset with max_count 65535 and linear clicks.
    // Rows whose numbers follow at once from the previous row carry their
    // expected result; the longer negative walk is left to the predictor.
    probe_row_t probe_rows [24] = '{
        // Read straight out of reset: nothing accumulated, not running.
        '{FUNC_READ,   16'd0,     32'd0,          1'b1, '{16'sd0, 16'd0, 1'b0}},
        // A sample while stopped is dropped, and so is a stop while stopped.
        '{FUNC_SAMPLE, 16'd1234,  32'd10,         1'b1, '{16'sd0, 16'd0, 1'b0}},
        '{FUNC_STOP,   16'd0,     32'd0,          1'b1, '{16'sd0, 16'd0, 1'b0}},
        '{FUNC_START,  16'd0,     32'd0,          1'b1, '{16'sd0, 16'd0, 1'b1}},
        // 400 counts forward with no elapsed time: speed pins at full scale.
        '{FUNC_SAMPLE, 16'd400,   32'd0,          1'b1, '{16'sd0, 16'hFFFF, 1'b1}},
        // A second start while running must not clear anything.
        '{FUNC_START,  16'd0,     32'd0,          1'b1, '{16'sd0, 16'hFFFF, 1'b1}},
        '{FUNC_READ,   16'd0,     32'd0,          1'b1, '{16'sd100, 16'hFFFF, 1'b1}},
        // Top of the counter range, longest elapsed time: 401 counts back
        // through the wrap, and a speed that rounds down to zero.
        '{FUNC_SAMPLE, 16'hFFFF,  32'hFFFF_FFFF,  1'b1, '{16'sd0, 16'd0, 1'b1}},
        // A total of -401 reads as -100 detents, the odd count stays behind.
        '{FUNC_READ,   16'd0,     32'd0,          1'b1, '{-16'sd100, 16'd0, 1'b1}},
        // Half a turn each way: on an exact half turn the direct distance wins the tie.
        '{FUNC_SAMPLE, 16'd32767, 32'd1,          1'b1, '{16'sd0, 16'hFFFF, 1'b1}},
        '{FUNC_SAMPLE, 16'd0,     32'd1000,       1'b1, '{16'sd0, 16'd32767, 1'b1}},
        '{FUNC_SAMPLE, 16'd32768, 32'd500,        1'b1, '{16'sd0, 16'hFFFF, 1'b1}},
        '{FUNC_SAMPLE, 16'd0,     32'd1000000,    1'b1, '{16'sd0, 16'd32, 1'b1}},
        // Keep walking backwards until the detent count overflows 16 bits.
        '{FUNC_SAMPLE, 16'd32769, 32'd7,          1'b0, '0},
        '{FUNC_SAMPLE, 16'd2,     32'd123456,     1'b0, '0},
        '{FUNC_SAMPLE, 16'd32771, 32'd0,          1'b0, '0},
        '{FUNC_READ,   16'd0,     32'd0,          1'b1, '{-16'sd32768, 16'hFFFF, 1'b1}},
        '{FUNC_SAMPLE, 16'hFFFF,  32'd3,          1'b0, '0},
        '{FUNC_SAMPLE, 16'hFFFF,  32'd5,          1'b0, '0},
        '{FUNC_READ,   16'd0,     32'd0,          1'b0, '0},
        '{FUNC_STOP,   16'd0,     32'd0,          1'b1, '{16'sd0, 16'd0, 1'b0}},
        '{FUNC_SAMPLE, 16'd100,   32'd1,          1'b1, '{16'sd0, 16'd0, 1'b0}},
        // A read while stopped still drains the accumulator.
        '{FUNC_READ,   16'd0,     32'd0,          1'b0, '0},
        '{FUNC_START,  16'd0,     32'd0,          1'b1, '{16'sd0, 16'd0, 1'b1}}
    };

    encoder_delta_accumulator #(
        .COUNT_WIDTH (COUNT_W),
        .TOTAL_WIDTH (TOTAL_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .counter_sample (counter_sample),
        .elapsed_ms     (elapsed_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .clicks         (clicks),
        .speed          (speed),
        .running        (running),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic signed [CLICKS_W-1:0] sat_click(input longint v);
        if (v > CLICK_HI)
            return CLICK_HI[CLICKS_W-1:0];
        if (v < CLICK_LO)
            return CLICK_LO[CLICKS_W-1:0];
        return v[CLICKS_W-1:0];
    endfunction

    // Advances the predicted encoder state by one command and returns the
    // result the block must hand back for it.
    function automatic eda_result_t advance_encoder(input eda_func_t op,
                                                    input logic [15:0] raw,
                                                    input logic [31:0] ms);
        eda_result_t res;
        longint      top;
        longint      cur;
        longint      prev;
        longint      direct;
        longint      wrapped;
        longint      travel;
        longint      span;
        longint      rate;
        longint      quot;
        bit          up;
        bit          fwd;

        res = '0;
        case (op)
            FUNC_START:
            begin
                if (!enc_active)
                begin
                    enc_last   = '0;
                    edge_sum   = 0;
                    speed_reg  = '0;
                    enc_active = 1'b1;
                end
            end
            FUNC_STOP:
                enc_active = 1'b0;
            FUNC_SAMPLE:
            begin
                if (enc_active)
                begin
                    // Both ends are clipped to the current top, which may
                    // have shrunk since the previous sample was stored.
                    top  = top_count;
                    cur  = raw;
                    prev = enc_last;
                    if (cur > top)
                        cur = top;
                    if (prev > top)
                        prev = top;
                    up      = (cur >= prev);
                    direct  = up ? cur - prev : prev - cur;
                    wrapped = top + 1 - direct;
                    if (direct <= wrapped)
                    begin
                        travel = direct;
                        fwd    = up;
                    end
                    else
                    begin
                        travel = wrapped;
                        fwd    = !up;
                    end
                    edge_sum = edge_sum + (fwd ? travel : -travel);
                    if (edge_sum > EDGE_HI)
                        edge_sum = EDGE_HI;
                    if (edge_sum < EDGE_LO)
                        edge_sum = EDGE_LO;
                    span = ms;
                    if (span == 0)
                        speed_reg = SPEED_MAX;
                    else
                    begin
                        rate = travel * 1000 / span;
                        speed_reg = (rate > 65535) ? SPEED_MAX : rate[15:0];
                    end
                    enc_last = cur[15:0];
                end
            end
            default:
            begin
                // Whole detents leave the total, truncated towards zero.
                quot     = edge_sum / 4;
                edge_sum = edge_sum - quot * 4;
                if (!cube_mode)
                    res.clicks = sat_click(quot);
                else if (quot >= CUBE_LIMIT)
                    res.clicks = CLICK_HI[CLICKS_W-1:0];
                else if (quot <= -CUBE_LIMIT)
                    res.clicks = CLICK_LO[CLICKS_W-1:0];
                else
                    res.clicks = sat_click(quot * quot * quot);
            end
        endcase
        res.speed   = speed_reg;
        res.running = enc_active;
        return res;
    endfunction

    // Offers one command and holds it until the transfer. Valid is left high
    // so that a following command goes out back to back.
    task automatic issue_item(input eda_func_t op, input logic [15:0] raw,
                              input logic [31:0] ms, input bit typed,
                              input eda_result_t want);
        eda_result_t predicted;

        in_valid       <= 1'b1;
        func           <= op;
        counter_sample <= raw;
        elapsed_ms     <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_encoder(op, raw, ms);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic maybe_gap();
        if (source_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Lets every owed result come back, then gives the block time to settle
    // before the register map is touched.
    task automatic quiesce();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MAX_COUNT)
            top_count = data;
        else if (idx == CFG_EXP_MODE)
            cube_mode = data[0];
    endtask

    // One random command. A third of the counts land near the previous one, as a
    // real encoder would, with a share of wild jumps, out of range values, the
    // extremes and exact half turns mixed in.
    task automatic random_item();
        int              pick;
        int              clipped;
        eda_func_t       op;
        logic [15:0]     raw;
        logic [31:0]     ms;

        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = FUNC_START;
        else if (pick < 13)
            op = FUNC_STOP;
        else if (pick < 65)
            op = FUNC_SAMPLE;
        else
            op = FUNC_READ;

        case ($urandom_range(0, 5))
            0, 1:
                raw = 16'(32'(enc_last) + $urandom_range(0, 80) - 32'd40);
            2:
                raw = 16'($urandom_range(0, 65535));
            3:
            begin
                clipped = top_count + $urandom_range(0, 20);
                raw = (clipped > 65535) ? 16'hFFFF : clipped[15:0];
            end
            4:
                raw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:
                raw = 16'((32'(enc_last) + (32'(top_count) + 1) / 2)
                          % (32'(top_count) + 1));
        endcase

        case ($urandom_range(0, 4))
            0:       ms = '0;
            1:       ms = $urandom_range(1, 50);
            2:       ms = $urandom_range(200, 5000);
            3:       ms = $urandom();
            default: ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase

        issue_item(op, raw, ms, 1'b0, '0);
    endtask

    // Receiving side: ready drops in short random bursts, and for one long
    // stretch on request so that the block backs up into its input.
    initial
    begin : sink_driver
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                while (hold_off > 0)
                begin
                    @(posedge clk);
                    hold_off--;
                end
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest owed result. The
    // handshake is sampled on the edge itself, before any driver updates.
    always @(posedge clk)
    begin : result_check
        eda_result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unowed result clicks %0d speed %0d running %0b",
                                       clicks, speed, running));
            else
            begin
                want = pending_results.pop_front();
                if (clicks !== want.clicks)
                    report_error($sformatf("clicks %0d, expected %0d", clicks, want.clicks));
                if (speed !== want.speed)
                    report_error($sformatf("speed %0d, expected %0d", speed, want.speed));
                if (running !== want.running)
                    report_error($sformatf("running %0b, expected %0b",
                                           running, want.running));
            end
        end
    end

    // Main sequence: reset, directed probes, the large-total sweep, then the
    // random phases, each under its own register settings.
    initial
    begin : stimulus
        logic [15:0] phase_top [N_PHASES];
        bit          phase_exp [N_PHASES];
        logic [15:0] sweep_count;
        int          phase_items;

        phase_top = '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd1000, 16'd0, 16'hFFFF};
        phase_exp = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        in_valid       <= 1'b0;
        func           <= FUNC_START;
        counter_sample <= '0;
        elapsed_ms     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_MAX_COUNT;
        cfg_data       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes, with some jitter on both channels already.
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        foreach (probe_rows[i])
        begin
            maybe_gap();
            issue_item(probe_rows[i].op, probe_rows[i].raw, probe_rows[i].ms,
                       probe_rows[i].typed, probe_rows[i].want);
        end

        // Sweep at full speed: restart from a clean total, pile up a large
        // total in half-turn steps, read it back so the detent count
        // saturates, then step back a little and read again.
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        issue_item(FUNC_STOP, '0, '0, 1'b0, '0);
        issue_item(FUNC_START, '0, '0, 1'b0, '0);
        sweep_count = '0;
        for (int n = 0; n < SWEEP_SAMPLES; n++)
        begin
            sweep_count = sweep_count + SWEEP_STEP;
            issue_item(FUNC_SAMPLE, sweep_count, 32'd1, 1'b0, '0);
        end
        issue_item(FUNC_READ, '0, '0, 1'b0, '0);
        issue_item(FUNC_SAMPLE, sweep_count - 16'd5, 32'd0, 1'b0, '0);
        issue_item(FUNC_READ, '0, '0, 1'b0, '0);

        // Random phases. State carries over from one phase to the next, so
        // a shrinking top also finds stored counts above the new limit.
        for (int p = 0; p < N_PHASES; p++)
        begin
            quiesce();
            if (p == 5)
            begin
                phase_top[p] = 16'($urandom_range(1, 65535));
                phase_exp[p] = 1'($urandom_range(0, 1));
            end
            write_register(CFG_MAX_COUNT, phase_top[p]);
            write_register(CFG_EXP_MODE, {15'($urandom_range(0, 32767)), phase_exp[p]});
            if (p == 2)
            begin
                write_register(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
                write_register(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
            end
            cfg_valid <= 1'b0;

            // The closing phase runs with both channels flat out.
            source_gaps = (p != N_PHASES - 1);
            sink_stalls = (p != N_PHASES - 1);
            phase_items = (p == N_PHASES - 1) ? LAST_LEN : PHASE_LEN;

            issue_item(FUNC_START, 16'($urandom_range(0, 65535)), $urandom(), 1'b0, '0);
            for (int n = 0; n < phase_items; n++)
            begin
                if (p == 3 && n == 40)
                    hold_off = 400;
                if (p == 4 && n == 50)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_results.size() != 0);
                end
                maybe_gap();
                random_item();
            end
        end

        quiesce();
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/eda_pkg.sv
design/encoder_delta_accumulator.sv
design/eda_checker.sv
verif/encoder_delta_accumulator_tb.sv
